// ===== hdl/actuator_min_on_off_guard_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the actuator minimum on/off guard
// Same-cycle and next-cycle implication property wrappers, empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef ACTUATOR_MIN_ON_OFF_GUARD_MACROS_SVH
`define ACTUATOR_MIN_ON_OFF_GUARD_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define AMOOG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define AMOOG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define AMOOG_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define AMOOG_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/amoog_pkg.sv =====
// ----------------------------------------------------------------------------
// Actuator minimum on/off guard package
// Shared widths, reset values, command, register and state codes, and the
// controller-to-datapath command bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package amoog_pkg;

	localparam int NUM_CHANNELS = 6;
	localparam int TIME_BITS    = 32;
	localparam int CFG_BITS     = 24;
	localparam int CHN_BITS     = 3;
	localparam int HUMID_FIRST  = 2;
	localparam int HUMID_LAST   = 5;

	localparam logic [CFG_BITS-1:0] RST_LIGHT_TIME = CFG_BITS'(5000);
	localparam logic [CFG_BITS-1:0] RST_PUMP_TIME  = CFG_BITS'(0);
	localparam logic [CFG_BITS-1:0] RST_HUMID_TIME = CFG_BITS'(30000);

	typedef logic [TIME_BITS-1:0] time_t;
	typedef logic [CFG_BITS-1:0]  cfg_t;

	typedef enum logic [2:0] {
		CMD_APPLY       = 3'd0,
		CMD_GROUP_APPLY = 3'd1,
		CMD_FORCE_OFF   = 3'd2,
		CMD_GROUP_OFF   = 3'd3,
		CMD_INIT        = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		REG_LIGHT_MIN_ON  = 3'd0,
		REG_LIGHT_MIN_OFF = 3'd1,
		REG_PUMP_MIN_ON   = 3'd2,
		REG_PUMP_MIN_OFF  = 3'd3,
		REG_HUMID_MIN_ON  = 3'd4,
		REG_HUMID_MIN_OFF = 3'd5,
		REG_GROUP_HOLD    = 3'd6
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_CALC   = 4'b0010,
		ST_COMMIT = 4'b0100,
		ST_RESULT = 4'b1000
	} state_t;

	typedef struct packed {
		logic load;
		logic calc;
		logic commit;
	} dp_cmd_t;

endpackage

`default_nettype wire

// ===== hdl/amoog_datapath.sv =====
// ----------------------------------------------------------------------------
// Actuator guard datapath
// Holds the hold-time registers, channel levels and change times, measures
// the elapsed time of the addressed channel or group and commits the command.
// ----------------------------------------------------------------------------
`default_nettype none

module amoog_datapath (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire  amoog_pkg::dp_cmd_t          cmd,
	input  wire  [2:0]                        command,
	input  wire  [amoog_pkg::CHN_BITS-1:0]    channel,
	input  wire                               want_on,
	input  wire  [31:0]                       now_ms,
	input  wire                               cfg_we,
	input  wire  [2:0]                        cfg_index,
	input  wire  [amoog_pkg::CFG_BITS-1:0]    cfg_data,
	output logic                              changed,
	output logic [amoog_pkg::NUM_CHANNELS-1:0] drive_mask,
	output logic                              group_on
);

	amoog_pkg::cfg_t light_on_q, light_off_q, pump_on_q, pump_off_q;
	amoog_pkg::cfg_t humid_on_q, humid_off_q, group_hold_q;

	amoog_pkg::cmd_t                   cmd_q;
	logic [amoog_pkg::CHN_BITS-1:0]    chn_q;
	logic                              want_q;
	amoog_pkg::time_t                  now_q;
	amoog_pkg::time_t                  held_q;
	amoog_pkg::time_t                  need_q;

	logic [amoog_pkg::NUM_CHANNELS-1:0] on_q;
	amoog_pkg::time_t                   last_q [amoog_pkg::NUM_CHANNELS];
	logic                               group_q;
	amoog_pkg::time_t                   group_time_q;
	logic                               changed_q;

	logic             chn_ok;
	amoog_pkg::time_t base_time;
	amoog_pkg::cfg_t  need_time;
	logic             held_ok;
	amoog_pkg::time_t init_light, init_pump, init_humid, init_group;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_on_q   <= amoog_pkg::RST_LIGHT_TIME;
			light_off_q  <= amoog_pkg::RST_LIGHT_TIME;
			pump_on_q    <= amoog_pkg::RST_PUMP_TIME;
			pump_off_q   <= amoog_pkg::RST_PUMP_TIME;
			humid_on_q   <= amoog_pkg::RST_HUMID_TIME;
			humid_off_q  <= amoog_pkg::RST_HUMID_TIME;
			group_hold_q <= amoog_pkg::RST_HUMID_TIME;
		end else if (cfg_we) begin
			case (cfg_index)
				amoog_pkg::REG_LIGHT_MIN_ON:  light_on_q   <= cfg_data;
				amoog_pkg::REG_LIGHT_MIN_OFF: light_off_q  <= cfg_data;
				amoog_pkg::REG_PUMP_MIN_ON:   pump_on_q    <= cfg_data;
				amoog_pkg::REG_PUMP_MIN_OFF:  pump_off_q   <= cfg_data;
				amoog_pkg::REG_HUMID_MIN_ON:  humid_on_q   <= cfg_data;
				amoog_pkg::REG_HUMID_MIN_OFF: humid_off_q  <= cfg_data;
				amoog_pkg::REG_GROUP_HOLD:    group_hold_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign chn_ok = (chn_q < amoog_pkg::CHN_BITS'(amoog_pkg::NUM_CHANNELS));

	always_comb begin
		if (cmd_q == amoog_pkg::CMD_GROUP_APPLY) begin
			base_time = group_time_q;
		end else if (chn_ok) begin
			base_time = last_q[chn_q];
		end else begin
			base_time = '0;
		end
		if (cmd_q == amoog_pkg::CMD_GROUP_APPLY) begin
			need_time = group_hold_q;
		end else if (chn_q == amoog_pkg::CHN_BITS'(0)) begin
			need_time = on_q[0] ? light_on_q : light_off_q;
		end else if (chn_q == amoog_pkg::CHN_BITS'(1)) begin
			need_time = on_q[1] ? pump_on_q : pump_off_q;
		end else if (chn_ok) begin
			need_time = on_q[chn_q] ? humid_on_q : humid_off_q;
		end else begin
			need_time = humid_off_q;
		end
	end

	assign held_ok    = (held_q >= need_q);
	assign init_light = now_q - amoog_pkg::time_t'(light_off_q);
	assign init_pump  = now_q - amoog_pkg::time_t'(pump_off_q);
	assign init_humid = now_q - amoog_pkg::time_t'(humid_off_q);
	assign init_group = now_q - amoog_pkg::time_t'(group_hold_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q  <= amoog_pkg::cmd_t'(command);
			chn_q  <= channel;
			want_q <= want_on;
			now_q  <= amoog_pkg::time_t'(now_ms);
		end
		if (cmd.calc) begin
			held_q <= now_q - base_time;
			need_q <= amoog_pkg::time_t'(need_time);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_q         <= '0;
			group_q      <= 1'b0;
			group_time_q <= '0;
			changed_q    <= 1'b0;
			for (int i = 0; i < amoog_pkg::NUM_CHANNELS; i++) begin
				last_q[i] <= '0;
			end
		end else if (cmd.commit) begin
			changed_q <= 1'b0;
			case (cmd_q)
				amoog_pkg::CMD_APPLY: begin
					if (chn_ok && (want_q != on_q[chn_q]) && held_ok) begin
						on_q[chn_q]   <= want_q;
						last_q[chn_q] <= now_q;
						changed_q     <= 1'b1;
					end
				end
				amoog_pkg::CMD_GROUP_APPLY: begin
					if ((want_q != group_q) && held_ok) begin
						for (int i = amoog_pkg::HUMID_FIRST; i <= amoog_pkg::HUMID_LAST; i++) begin
							on_q[i]   <= want_q;
							last_q[i] <= now_q;
						end
						group_q      <= want_q;
						group_time_q <= now_q;
						changed_q    <= 1'b1;
					end
				end
				amoog_pkg::CMD_FORCE_OFF: begin
					if (chn_ok && on_q[chn_q]) begin
						on_q[chn_q]   <= 1'b0;
						last_q[chn_q] <= now_q;
					end
				end
				amoog_pkg::CMD_GROUP_OFF: begin
					for (int i = amoog_pkg::HUMID_FIRST; i <= amoog_pkg::HUMID_LAST; i++) begin
						on_q[i] <= 1'b0;
						if (group_q) begin
							last_q[i] <= now_q;
						end
					end
					if (group_q) begin
						group_time_q <= now_q;
					end
					group_q <= 1'b0;
				end
				amoog_pkg::CMD_INIT: begin
					on_q      <= '0;
					last_q[0] <= init_light;
					last_q[1] <= init_pump;
					for (int i = amoog_pkg::HUMID_FIRST; i <= amoog_pkg::HUMID_LAST; i++) begin
						last_q[i] <= init_humid;
					end
					group_q      <= 1'b0;
					group_time_q <= init_group;
				end
				default: ;
			endcase
		end
	end

	assign changed    = changed_q;
	assign drive_mask = on_q;
	assign group_on   = group_q;

endmodule

`default_nettype wire

// ===== hdl/amoog_ctrl.sv =====
// ----------------------------------------------------------------------------
// Actuator guard controller
// Sequences one command through load, elapsed-time measurement, commit and
// the one-cycle result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

`include "actuator_min_on_off_guard_macros.svh"

module amoog_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	output logic                busy,
	output logic                done,
	output amoog_pkg::dp_cmd_t  cmd
);

	amoog_pkg::state_t state_q;
	amoog_pkg::state_t state_nxt;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			amoog_pkg::ST_IDLE:   if (start) state_nxt = amoog_pkg::ST_CALC;
			amoog_pkg::ST_CALC:   state_nxt = amoog_pkg::ST_COMMIT;
			amoog_pkg::ST_COMMIT: state_nxt = amoog_pkg::ST_RESULT;
			amoog_pkg::ST_RESULT: state_nxt = amoog_pkg::ST_IDLE;
			default:              state_nxt = amoog_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= amoog_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign busy       = (state_q != amoog_pkg::ST_IDLE);
	assign done       = (state_q == amoog_pkg::ST_RESULT);
	assign cmd.load   = (state_q == amoog_pkg::ST_IDLE) && start;
	assign cmd.calc   = (state_q == amoog_pkg::ST_CALC);
	assign cmd.commit = (state_q == amoog_pkg::ST_COMMIT);

	`AMOOG_ASSERT_NEXT(a_accept_calc, clk, arst_n, start && !busy, cmd.calc)
	`AMOOG_ASSERT_NEXT(a_commit_done, clk, arst_n, cmd.commit, done)
	`AMOOG_ASSERT_NEXT(a_done_idle, clk, arst_n, done, !busy)
	`AMOOG_ASSERT_NOW(a_load_idle, clk, arst_n, cmd.load, !done && !cmd.commit)

endmodule

`default_nettype wire

// ===== hdl/actuator_min_on_off_guard.sv =====
// ----------------------------------------------------------------------------
// Actuator minimum on/off guard
// Enforces minimum on and off hold times on six on/off actuator channels and
// a shared hold time on the four-channel humidifier group.
// ----------------------------------------------------------------------------
// A command is taken when start is high while busy is low. Every command
// then runs through these steps: the command is latched, the elapsed time
// of the addressed channel or group is measured in one 32-bit subtract, the
// comparison with the hold time and the state update are committed, and
// done is high for exactly one cycle with changed, drive_mask and group_on
// valid. The receiver cannot stall; the result must be taken in that cycle.
// busy drops in the cycle after the strobe, so no new command is taken
// before the last has finished. drive_mask and group_on always show the
// current levels. Hold times are to be written through cfg_we, cfg_index
// and cfg_data while no command is in progress; the block does not enforce it.
`default_nettype none

module actuator_min_on_off_guard (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                start,
	output logic                               busy,
	input  wire  [2:0]                         command,
	input  wire  [amoog_pkg::CHN_BITS-1:0]     channel,
	input  wire                                want_on,
	input  wire  [31:0]                        now_ms,
	input  wire                                cfg_we,
	input  wire  [2:0]                         cfg_index,
	input  wire  [amoog_pkg::CFG_BITS-1:0]     cfg_data,
	output logic                               done,
	output logic                               changed,
	output logic [amoog_pkg::NUM_CHANNELS-1:0] drive_mask,
	output logic                               group_on
);

	amoog_pkg::dp_cmd_t dp_cmd;

	amoog_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (dp_cmd)
	);

	amoog_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (dp_cmd),
		.command    (command),
		.channel    (channel),
		.want_on    (want_on),
		.now_ms     (now_ms),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.changed    (changed),
		.drive_mask (drive_mask),
		.group_on   (group_on)
	);

endmodule

`default_nettype wire
